// ----- design/fts_pkg.sv -----
// shared constants, codes and types of the four-thread scheduler
package fts_pkg;

  // thread slots and derived widths
  localparam int unsigned THREADS   = 4;
  localparam int unsigned ID_W      = $clog2(THREADS);
  // ping-pong sweep period: 0 .. THREADS-1 .. 1
  localparam int unsigned SWEEP_LEN = 2 * THREADS - 2;
  localparam int unsigned POS_W     = $clog2(2 * SWEEP_LEN);

  // port field widths
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned SP_W      = 8;
  localparam int unsigned STATUS_W  = 2;
  localparam int unsigned TID_W     = 2;
  localparam int unsigned VMASK_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 8;

  // register reset values and the initial frame size
  localparam logic [SP_W-1:0] STACK_BASE_RST   = 8'h3F;
  localparam logic [SP_W-1:0] STACK_STRIDE_RST = 8'h10;
  localparam logic [SP_W-1:0] FRAME_BYTES      = 8'd7;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STACK_STRIDE = 2'd1;

  typedef enum logic [REQ_W-1:0] {
    REQ_CREATE = 2'd0,
    REQ_YIELD  = 2'd1,
    REQ_TICK   = 2'd2,
    REQ_EXIT   = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // candidate threads offered by the selector
  typedef struct packed {
    logic            free_found;
    logic [ID_W-1:0] free_id;
    logic            rr_found;
    logic [ID_W-1:0] rr_id;
    logic            tick_found;
    logic [ID_W-1:0] tick_id;
    logic            tick_up;
    logic            low_found;
    logic [ID_W-1:0] low_id;
  } fts_pick_t;

endpackage

// ----- design/fts_pick.sv -----
// thread selection: lowest free slot, round-robin, ping-pong sweep, lowest valid
module fts_pick (
  input  logic [fts_pkg::THREADS-1:0] valid_i,
  input  logic [fts_pkg::THREADS-1:0] exit_mask_i,
  input  logic [fts_pkg::ID_W-1:0]    cur_id_i,
  input  logic                        sweep_up_i,
  output fts_pkg::fts_pick_t          pick_o
);

  localparam int unsigned T = fts_pkg::THREADS;
  localparam int unsigned P = fts_pkg::SWEEP_LEN;

  logic [fts_pkg::POS_W-1:0] pos0;

  logic                      free_found;
  logic [fts_pkg::ID_W-1:0]  free_id;
  logic                      rr_found;
  logic [fts_pkg::ID_W-1:0]  rr_id;
  logic                      tick_found;
  logic [fts_pkg::ID_W-1:0]  tick_id;
  logic                      tick_up;
  logic                      low_found;
  logic [fts_pkg::ID_W-1:0]  low_id;

  // lowest free slot and lowest valid thread after exit
  always_comb begin
    free_found = ~(&valid_i);
    free_id    = '0;
    low_found  = |exit_mask_i;
    low_id     = '0;
    for (int i = T - 1; i >= 0; i--) begin
      if (!valid_i[i]) begin
        free_id = fts_pkg::ID_W'(i);
      end
      if (exit_mask_i[i]) begin
        low_id = fts_pkg::ID_W'(i);
      end
    end
  end

  // round-robin: next valid after the current one, the current one last
  always_comb begin
    int c;
    rr_found = 1'b0;
    rr_id    = '0;
    for (int k = 1; k <= T; k++) begin
      c = int'(cur_id_i) + k;
      if (c >= T) begin
        c = c - T;
      end
      if (!rr_found && valid_i[c]) begin
        rr_found = 1'b1;
        rr_id    = fts_pkg::ID_W'(c);
      end
    end
  end

  // position of the current thread within the sweep period
  always_comb begin
    if (sweep_up_i || cur_id_i == '0) begin
      pos0 = fts_pkg::POS_W'(cur_id_i);
    end else begin
      pos0 = fts_pkg::POS_W'(P - int'(cur_id_i));
    end
  end

  // ping-pong sweep: first valid position after the current one
  always_comb begin
    int q;
    int id;
    tick_found = 1'b0;
    tick_id    = '0;
    tick_up    = sweep_up_i;
    for (int k = 1; k <= P; k++) begin
      q = int'(pos0) + k;
      if (q >= P) begin
        q = q - P;
      end
      id = (q < T) ? q : P - q;
      if (!tick_found && valid_i[id]) begin
        tick_found = 1'b1;
        tick_id    = fts_pkg::ID_W'(id);
        tick_up    = (q != 0) && (q <= T - 1);
      end
    end
  end

  // candidates gathered in field order
  assign pick_o = {free_found, free_id, rr_found, rr_id, tick_found, tick_id, tick_up,
                   low_found, low_id};

endmodule

// ----- design/four_thread_scheduler.sv -----
// top level of the four-thread scheduler: registers, state update and handshakes
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------------------
//   cfg     | in        | cfg_valid_i/ready_o  | cfg_idx_i, cfg_data_i
//   in      | in        | in_valid_i/ready_o   | req_type_i, cur_sp_i
//   out     | out       | out_valid_o/ready_i  | status_o, thread_id_o, restore_sp_o,
//           |           |                      | valid_mask_o
//
// one request per cycle sustained while the receiver takes results; a transaction
// passes the input register, then the single selection pass, then the result
// register, from which its result is offered.
// reset empties the thread mask, clears the running flag and sets the sweep
// upward; base and stride return to their defaults. saved pointers need no reset.
// a stalled result holds the result register; the input register still takes
// a new transaction whenever the result register frees up in the same cycle.
module four_thread_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [fts_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fts_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [fts_pkg::REQ_W-1:0]      req_type_i,
  input  logic [fts_pkg::SP_W-1:0]       cur_sp_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [fts_pkg::STATUS_W-1:0]   status_o,
  output logic [fts_pkg::TID_W-1:0]      thread_id_o,
  output logic [fts_pkg::SP_W-1:0]       restore_sp_o,
  output logic [fts_pkg::VMASK_W-1:0]    valid_mask_o
);

  localparam int unsigned T    = fts_pkg::THREADS;
  localparam int unsigned ID_W = fts_pkg::ID_W;
  localparam int unsigned SP_W = fts_pkg::SP_W;

  // configuration
  logic [SP_W-1:0] stack_base_q, stack_stride_q;

  // scheduler state
  logic [T-1:0]    thread_valid_q, thread_valid_d;
  logic [ID_W-1:0] current_id_q, current_id_d;
  logic            current_live_q, current_live_d;
  logic            sweep_up_q, sweep_up_d;
  logic [SP_W-1:0] saved_sp_q [T];

  // input register
  logic                  inq_valid_q;
  fts_pkg::req_e         inq_req_q;
  logic [SP_W-1:0]       inq_sp_q;

  // result register
  logic                  res_valid_q;
  fts_pkg::status_e      res_status_q, res_status_d;
  logic [ID_W-1:0]       res_id_q, res_id_d;
  logic [SP_W-1:0]       res_sp_q, res_sp_d;
  logic [T-1:0]          res_mask_q;

  logic                  advance;
  logic [T-1:0]          exit_mask;
  fts_pkg::fts_pick_t    pick;
  logic [SP_W+ID_W-1:0]  stride_prod;
  logic [SP_W-1:0]       init_sp;
  logic                  do_save;
  logic                  wr_en;
  logic [ID_W-1:0]       wr_id;
  logic [SP_W-1:0]       wr_data;
  logic [ID_W-1:0]       rd_id;
  logic [SP_W-1:0]       rd_data;

  // handshakes
  assign cfg_ready_o = 1'b1;
  assign advance     = inq_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o  = !inq_valid_q || advance;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stack_base_q   <= fts_pkg::STACK_BASE_RST;
      stack_stride_q <= fts_pkg::STACK_STRIDE_RST;
    end else if (cfg_valid_i) begin
      if (cfg_idx_i == fts_pkg::CFG_STACK_BASE) begin
        stack_base_q <= cfg_data_i;
      end else if (cfg_idx_i == fts_pkg::CFG_STACK_STRIDE) begin
        stack_stride_q <= cfg_data_i;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inq_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      inq_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      inq_req_q <= fts_pkg::req_e'(req_type_i);
      inq_sp_q  <= cur_sp_i;
    end
  end

  // mask seen by exit once the running thread is dropped
  always_comb begin
    exit_mask = thread_valid_q;
    if (current_live_q) begin
      exit_mask[current_id_q] = 1'b0;
    end
  end

  fts_pick u_pick (
    .valid_i     (thread_valid_q),
    .exit_mask_i (exit_mask),
    .cur_id_i    (current_id_q),
    .sweep_up_i  (sweep_up_q),
    .pick_o      (pick)
  );

  // initial stack pointer of the new slot, wrapping at eight bits
  assign stride_prod = {{ID_W{1'b0}}, stack_stride_q} * {{SP_W{1'b0}}, pick.free_id};
  assign init_sp     = SP_W'(stack_base_q + stride_prod[SP_W-1:0] + fts_pkg::FRAME_BYTES);

  assign do_save = current_live_q &&
                   (inq_req_q == fts_pkg::REQ_YIELD || inq_req_q == fts_pkg::REQ_TICK);

  // thread whose saved pointer is read
  always_comb begin
    unique case (inq_req_q)
      fts_pkg::REQ_YIELD: rd_id = pick.rr_id;
      fts_pkg::REQ_TICK:  rd_id = pick.tick_id;
      fts_pkg::REQ_EXIT:  rd_id = pick.low_id;
      default:            rd_id = '0;
    endcase
  end

  // saved pointer of the chosen thread, bypassing a save made in this pass
  assign rd_data = (do_save && rd_id == current_id_q) ? inq_sp_q : saved_sp_q[rd_id];

  // request decode and next state
  always_comb begin
    thread_valid_d = thread_valid_q;
    current_id_d   = current_id_q;
    current_live_d = current_live_q;
    sweep_up_d     = sweep_up_q;
    res_status_d   = fts_pkg::ST_OK;
    res_id_d       = '0;
    res_sp_d       = '0;
    wr_en          = do_save;
    wr_id          = current_id_q;
    wr_data        = inq_sp_q;
    unique case (inq_req_q)
      fts_pkg::REQ_CREATE: begin
        if (!pick.free_found) begin
          res_status_d = fts_pkg::ST_FULL;
        end else begin
          thread_valid_d[pick.free_id] = 1'b1;
          wr_en    = 1'b1;
          wr_id    = pick.free_id;
          wr_data  = init_sp;
          res_id_d = pick.free_id;
          res_sp_d = init_sp;
          if (!current_live_q) begin
            current_id_d   = pick.free_id;
            current_live_d = 1'b1;
          end
        end
      end
      fts_pkg::REQ_YIELD: begin
        if (pick.rr_found) begin
          current_id_d   = pick.rr_id;
          current_live_d = 1'b1;
          res_id_d       = pick.rr_id;
          res_sp_d       = rd_data;
        end else begin
          current_live_d = 1'b0;
          res_status_d   = fts_pkg::ST_EMPTY;
        end
      end
      fts_pkg::REQ_TICK: begin
        if (pick.tick_found) begin
          current_id_d   = pick.tick_id;
          current_live_d = 1'b1;
          sweep_up_d     = pick.tick_up;
          res_id_d       = pick.tick_id;
          res_sp_d       = rd_data;
        end else begin
          current_live_d = 1'b0;
          res_status_d   = fts_pkg::ST_EMPTY;
        end
      end
      fts_pkg::REQ_EXIT: begin
        thread_valid_d = exit_mask;
        if (pick.low_found) begin
          current_id_d   = pick.low_id;
          current_live_d = 1'b1;
          res_id_d       = pick.low_id;
          res_sp_d       = rd_data;
        end else begin
          current_live_d = 1'b0;
          res_status_d   = fts_pkg::ST_EMPTY;
        end
      end
      default: begin
        res_status_d = fts_pkg::ST_OK;
      end
    endcase
  end

  // scheduler state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thread_valid_q <= '0;
      current_id_q   <= '0;
      current_live_q <= 1'b0;
      sweep_up_q     <= 1'b1;
    end else if (advance) begin
      thread_valid_q <= thread_valid_d;
      current_id_q   <= current_id_d;
      current_live_q <= current_live_d;
      sweep_up_q     <= sweep_up_d;
    end
  end

  // saved stack pointers
  always_ff @(posedge clk_i) begin
    if (advance && wr_en) begin
      saved_sp_q[wr_id] <= wr_data;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_status_q <= res_status_d;
      res_id_q     <= res_id_d;
      res_sp_q     <= res_sp_d;
      res_mask_q   <= thread_valid_d;
    end
  end

  // result ports
  assign out_valid_o  = res_valid_q;
  assign status_o     = res_status_q;
  assign thread_id_o  = fts_pkg::TID_W'(res_id_q);
  assign restore_sp_o = res_sp_q;
  assign valid_mask_o = fts_pkg::VMASK_W'(res_mask_q);

endmodule

// ----- tb/tb_four_thread_scheduler.sv -----
// self-checking testbench of the four-thread scheduler with its own scheduling predictor
module tb_four_thread_scheduler;
  timeunit 1ns;
  timeprecision 1ps;

  // one request as the sender presents it
  typedef struct packed {
    fts_pkg::req_e            req;
    logic [fts_pkg::SP_W-1:0] sp;
  } sched_req_t;

  // one predicted result transaction
  typedef struct packed {
    fts_pkg::status_e            status;
    logic [fts_pkg::TID_W-1:0]   tid;
    logic [fts_pkg::SP_W-1:0]    rsp;
    logic [fts_pkg::VMASK_W-1:0] vmask;
  } switch_result_t;

  logic                           clk_i        = 1'b0;
  logic                           rst_ni       = 1'b0;
  logic                           cfg_valid_i  = 1'b0;
  logic                           cfg_ready_o;
  logic [fts_pkg::CFG_IDX_W-1:0]  cfg_idx_i    = fts_pkg::CFG_STACK_BASE;
  logic [fts_pkg::CFG_W-1:0]      cfg_data_i   = '0;
  logic                           in_valid_i   = 1'b0;
  logic                           in_ready_o;
  logic [fts_pkg::REQ_W-1:0]      req_type_i   = fts_pkg::REQ_CREATE;
  logic [fts_pkg::SP_W-1:0]       cur_sp_i     = '0;
  logic                           out_valid_o;
  logic                           out_ready_i  = 1'b0;
  logic [fts_pkg::STATUS_W-1:0]   status_o;
  logic [fts_pkg::TID_W-1:0]      thread_id_o;
  logic [fts_pkg::SP_W-1:0]       restore_sp_o;
  logic [fts_pkg::VMASK_W-1:0]    valid_mask_o;

  four_thread_scheduler u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .cur_sp_i     (cur_sp_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .thread_id_o  (thread_id_o),
    .restore_sp_o (restore_sp_o),
    .valid_mask_o (valid_mask_o)
  );

  // 2 ns clock, starting low
  always begin
    #1;
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
  end

  // predictor copy of the scheduler state and registers
  logic [fts_pkg::SP_W-1:0]    pred_base   = fts_pkg::STACK_BASE_RST;
  logic [fts_pkg::SP_W-1:0]    pred_stride = fts_pkg::STACK_STRIDE_RST;
  logic [fts_pkg::THREADS-1:0] pred_valid  = '0;
  logic [fts_pkg::ID_W-1:0]    pred_cur    = '0;
  logic                        pred_live   = 1'b0;
  logic                        pred_up     = 1'b1;
  logic [fts_pkg::SP_W-1:0]    pred_sp [fts_pkg::THREADS];

  sched_req_t     request_q[$];
  switch_result_t switch_result_q[$];
  int unsigned    n_req_taken = 0;
  int unsigned    n_res_seen  = 0;
  int unsigned    fail_cnt    = 0;

  // work out the answer to one request and advance the predicted state
  function automatic switch_result_t schedule_request(fts_pkg::req_e req,
                                                      logic [fts_pkg::SP_W-1:0] sp);
    switch_result_t           r;
    logic [fts_pkg::ID_W-1:0] c;
    logic                     up;
    logic                     found;
    int                       k;
    r        = '0;
    r.status = fts_pkg::ST_EMPTY;
    c        = pred_cur;
    up       = pred_up;
    found    = 1'b0;
    case (req)
      fts_pkg::REQ_CREATE: begin
        if (&pred_valid) begin
          r.status = fts_pkg::ST_FULL;
        end else begin
          // lowest free slot
          for (k = fts_pkg::THREADS - 1; k >= 0; k--) begin
            if (!pred_valid[k]) c = fts_pkg::ID_W'(k);
          end
          pred_valid[c] = 1'b1;
          pred_sp[c]    = fts_pkg::SP_W'(pred_base + fts_pkg::SP_W'(c) * pred_stride
                                         + fts_pkg::FRAME_BYTES);
          if (!pred_live) begin
            pred_cur  = c;
            pred_live = 1'b1;
          end
          r.status = fts_pkg::ST_OK;
          r.tid    = c;
          r.rsp    = pred_sp[c];
        end
      end
      fts_pkg::REQ_YIELD: begin
        if (pred_live) pred_sp[pred_cur] = sp;
        // next valid thread round-robin
        for (k = 0; k < fts_pkg::THREADS; k++) begin
          if (!found) begin
            c = (c == fts_pkg::ID_W'(fts_pkg::THREADS - 1)) ? '0 : c + 1'b1;
            found = pred_valid[c];
          end
        end
      end
      fts_pkg::REQ_TICK: begin
        if (pred_live) pred_sp[pred_cur] = sp;
        // ping-pong sweep, turning at both ends
        for (k = 0; k < 2 * fts_pkg::THREADS; k++) begin
          if (!found) begin
            if (up) begin
              if (c == fts_pkg::ID_W'(fts_pkg::THREADS - 1)) begin
                up = 1'b0;
                c  = fts_pkg::ID_W'(fts_pkg::THREADS - 2);
              end else begin
                c = c + 1'b1;
              end
            end else begin
              if (c == '0) begin
                up = 1'b1;
                c  = fts_pkg::ID_W'(1);
              end else begin
                c = c - 1'b1;
              end
            end
            found = pred_valid[c];
          end
        end
        if (found) pred_up = up;
      end
      default: begin
        if (pred_live) pred_valid[pred_cur] = 1'b0;
        // lowest remaining thread
        for (k = 0; k < fts_pkg::THREADS; k++) begin
          if (!found && pred_valid[k]) begin
            c     = fts_pkg::ID_W'(k);
            found = 1'b1;
          end
        end
      end
    endcase
    if (req != fts_pkg::REQ_CREATE) begin
      if (found) begin
        pred_cur  = c;
        pred_live = 1'b1;
        r.status  = fts_pkg::ST_OK;
        r.tid     = c;
        r.rsp     = pred_sp[c];
      end else begin
        pred_live = 1'b0;
      end
    end
    r.vmask = pred_valid;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned expv,
                                      logic [fts_pkg::SP_W-1:0] act);
    if (act !== fts_pkg::SP_W'(expv)) begin
      $error("%s: expected %0d, got %0d", name, expv, act);
      fail_cnt++;
    end
  endfunction

  // register write, only while the block is idle
  task automatic write_reg(logic [fts_pkg::CFG_IDX_W-1:0] idx, logic [fts_pkg::CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == fts_pkg::CFG_STACK_BASE) pred_base = data;
    else pred_stride = data;
  endtask

  task automatic queue_item(fts_pkg::req_e req, logic [fts_pkg::SP_W-1:0] sp);
    request_q.push_back('{req: req, sp: sp});
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (request_q.size() != 0 || in_valid_i || n_req_taken != n_res_seen);
  endtask

  // request driver: bursts with random gaps, now and then a full drain
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned taken_now;
  logic        drain_wait = 1'b0;
  logic        took;
  logic        nxt_valid;
  sched_req_t  next_req;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      req_type_i <= fts_pkg::REQ_CREATE;
      cur_sp_i   <= '0;
      burst_left = 0;
      gap_left   = 0;
      drain_wait = 1'b0;
    end else begin
      took = in_valid_i && in_ready_o;
      if (took) begin
        switch_result_q.push_back(schedule_request(fts_pkg::req_e'(req_type_i), cur_sp_i));
        n_req_taken <= n_req_taken + 1;
      end
      taken_now = n_req_taken + (took ? 1 : 0);
      if (!(in_valid_i && !in_ready_o)) begin
        nxt_valid = 1'b0;
        if (gap_left != 0) begin
          gap_left--;
        end else if (!(drain_wait && taken_now != n_res_seen) && request_q.size() != 0) begin
          next_req = request_q.pop_front();
          req_type_i <= next_req.req;
          cur_sp_i   <= next_req.sp;
          nxt_valid  = 1'b1;
          drain_wait = 1'b0;
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          burst_left--;
          if (burst_left == 0) begin
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            drain_wait = ($urandom_range(0, 19) == 0);
          end
        end
        in_valid_i <= nxt_valid;
      end
    end
  end

  // result monitor and receiver stall pattern
  int unsigned     stall_left = 0;
  int unsigned     stall_mode = 0;
  logic [2:0]      pat_cnt    = '0;
  logic [2:0]      pat_duty   = 3'd4;
  logic            nxt_ready;
  switch_result_t  exp_res;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (switch_result_q.size() == 0) begin
          $error("result transaction with none expected");
          fail_cnt++;
        end else begin
          exp_res = switch_result_q.pop_front();
          check_field("status",     exp_res.status, fts_pkg::SP_W'(status_o));
          check_field("thread_id",  exp_res.tid,    fts_pkg::SP_W'(thread_id_o));
          check_field("restore_sp", exp_res.rsp,    restore_sp_o);
          check_field("valid_mask", exp_res.vmask,  fts_pkg::SP_W'(valid_mask_o));
        end
        n_res_seen <= n_res_seen + 1;
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(16, 160);
        pat_duty   = 3'($urandom_range(1, 7));
      end
      stall_left--;
      pat_cnt = pat_cnt + 1'b1;
      case (stall_mode)
        0:       nxt_ready = 1'b1;
        1:       nxt_ready = 1'($urandom_range(0, 1));
        2:       nxt_ready = (pat_cnt < pat_duty);
        default: nxt_ready = ($urandom_range(0, 7) == 0);
      endcase
      out_ready_i <= nxt_ready;
    end
  end

  // stimulus phases
  logic [fts_pkg::CFG_W-1:0] ph_base;
  logic [fts_pkg::CFG_W-1:0] ph_stride;
  int unsigned               create_pct;
  int unsigned               exit_pct;
  int unsigned               roll;
  fts_pkg::req_e             rnd_req;

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // empty block, filling up, full, sweeps, exits down to empty and back
    queue_item(fts_pkg::REQ_YIELD,  8'hFF);
    queue_item(fts_pkg::REQ_TICK,   8'h00);
    queue_item(fts_pkg::REQ_EXIT,   8'hA5);
    queue_item(fts_pkg::REQ_CREATE, 8'h00);
    queue_item(fts_pkg::REQ_CREATE, 8'hFF);
    queue_item(fts_pkg::REQ_CREATE, 8'h12);
    queue_item(fts_pkg::REQ_CREATE, 8'h34);
    queue_item(fts_pkg::REQ_CREATE, 8'h56);
    queue_item(fts_pkg::REQ_YIELD,  8'hFF);
    queue_item(fts_pkg::REQ_YIELD,  8'h00);
    queue_item(fts_pkg::REQ_TICK,   8'hAA);
    queue_item(fts_pkg::REQ_TICK,   8'h55);
    queue_item(fts_pkg::REQ_TICK,   8'h0F);
    queue_item(fts_pkg::REQ_TICK,   8'hF0);
    queue_item(fts_pkg::REQ_EXIT,   8'h11);
    queue_item(fts_pkg::REQ_CREATE, 8'h22);
    queue_item(fts_pkg::REQ_EXIT,   8'h33);
    queue_item(fts_pkg::REQ_EXIT,   8'h44);
    queue_item(fts_pkg::REQ_EXIT,   8'h66);
    queue_item(fts_pkg::REQ_EXIT,   8'h77);
    queue_item(fts_pkg::REQ_EXIT,   8'h88);
    queue_item(fts_pkg::REQ_TICK,   8'h99);
    queue_item(fts_pkg::REQ_CREATE, 8'hCC);
    queue_item(fts_pkg::REQ_YIELD,  8'h80);
    queue_item(fts_pkg::REQ_TICK,   8'h7F);
    wait_drained();

    for (int ph = 0; ph < 10; ph++) begin
      repeat (4) @(posedge clk_i);
      case (ph)
        0:       begin ph_base = 8'h00; ph_stride = 8'h00; end
        1:       begin ph_base = 8'hFF; ph_stride = 8'hFF; end
        2:       begin ph_base = 8'hF8; ph_stride = 8'h55; end
        3:       begin
          ph_base   = fts_pkg::STACK_BASE_RST;
          ph_stride = fts_pkg::STACK_STRIDE_RST;
        end
        4:       begin ph_base = 8'h01; ph_stride = 8'h80; end
        default: begin
          ph_base   = fts_pkg::CFG_W'($urandom_range(0, 255));
          ph_stride = fts_pkg::CFG_W'($urandom_range(0, 255));
        end
      endcase
      if (ph % 2 == 0) begin
        write_reg(fts_pkg::CFG_STACK_BASE, ph_base);
        write_reg(fts_pkg::CFG_STACK_STRIDE, ph_stride);
      end else begin
        write_reg(fts_pkg::CFG_STACK_STRIDE, ph_stride);
        write_reg(fts_pkg::CFG_STACK_BASE, ph_base);
      end
      @(negedge clk_i);
      // per-phase mix so the mask spends time full, sparse and empty
      create_pct = $urandom_range(10, 60);
      exit_pct   = $urandom_range(8, 35);
      for (int i = 0; i < 173; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < create_pct) rnd_req = fts_pkg::REQ_CREATE;
        else if (roll < create_pct + exit_pct) rnd_req = fts_pkg::REQ_EXIT;
        else if ($urandom_range(0, 1) == 0) rnd_req = fts_pkg::REQ_YIELD;
        else rnd_req = fts_pkg::REQ_TICK;
        queue_item(rnd_req, fts_pkg::SP_W'($urandom_range(0, 255)));
      end
      wait_drained();
    end

    repeat (8) @(posedge clk_i);
    if (fail_cnt == 0) begin
      $display("PASS four_thread_scheduler");
    end else begin
      $display("FAIL four_thread_scheduler");
    end
    $finish;
  end

  // watchdog
  initial begin
    #800_000;
    $display("FAIL four_thread_scheduler");
    $finish;
  end

endmodule
